@@ rtl/core/cdq_pkg.sv @@
// Shared types and constants for the circular deque.
package cdq_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int ENTRY_W        = 32;
  localparam int OCC_W          = 6;

  typedef enum logic [1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_BACK  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_NOP        = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    req_type_t          req_type;
    logic [ENTRY_W-1:0] entry_data;
  } req_item_t;

  typedef struct packed {
    status_t            status;
    logic [ENTRY_W-1:0] popped_data;
    logic [OCC_W-1:0]   occupancy;
    logic               full_flag;
    logic               empty_flag;
  } result_item_t;

  typedef struct packed {
    logic load_req;
    logic exec;
    logic load_out;
  } ctl_cmd_t;

endpackage

@@ rtl/core/cdq_ram.sv @@
// Generic single-port RAM with registered read data.
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wr_data,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wr_data;
      end else begin
        rd_data <= mem[addr];
      end
    end
  end

endmodule

@@ rtl/core/cdq_ctrl.sv @@
// Controller state machine that sequences each deque request.
module cdq_ctrl
  import cdq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output ctl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FINISH
  } state_t;

  state_t state;
  logic   slot_free;

  assign in_ready     = (state == S_IDLE);
  assign slot_free    = !out_valid || out_ready;
  assign cmd.load_req = in_valid && in_ready;
  assign cmd.exec     = (state == S_EXEC);
  assign cmd.load_out = (state == S_FINISH) && slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.load_req) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/cdq_datapath.sv @@
// Datapath with the pointers, the entry store and the result register.
module cdq_datapath
  import cdq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  ctl_cmd_t     cmd,
  input  req_item_t    in_data,
  output result_item_t out_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [PTR_W:0]   DEPTH_EXT = (PTR_W + 1)'(DEPTH);

  req_item_t        req;
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [PTR_W-1:0] head_next;
  logic [PTR_W-1:0] tail_next;
  logic [PTR_W-1:0] head_inc;
  logic [PTR_W-1:0] head_dec;
  logic [PTR_W-1:0] tail_inc;
  status_t          res_status;
  status_t          res_status_next;
  logic             pop_ok;
  logic             pop_ok_next;
  logic             is_full;
  logic             is_empty;
  logic             ram_en;
  logic             ram_we;
  logic [PTR_W-1:0] ram_addr;
  logic [DATA_WIDTH-1:0] ram_rd_data;
  logic [PTR_W:0]   occ_diff;

  assign head_inc = (head == PTR_LAST) ? '0 : head + 1'b1;
  assign head_dec = (head == '0) ? PTR_LAST : head - 1'b1;
  assign tail_inc = (tail == PTR_LAST) ? '0 : tail + 1'b1;
  assign is_full  = (tail_inc == head);
  assign is_empty = (head == tail);

  always_comb begin
    head_next       = head;
    tail_next       = tail;
    res_status_next = ST_DONE;
    pop_ok_next     = 1'b0;
    ram_en          = 1'b0;
    ram_we          = 1'b0;
    ram_addr        = head;
    case (req.req_type)
      REQ_PUSH_FRONT: begin
        if (is_full) begin
          res_status_next = ST_FULL;
        end else begin
          ram_en    = cmd.exec;
          ram_we    = 1'b1;
          ram_addr  = head;
          head_next = head_dec;
        end
      end
      REQ_PUSH_BACK: begin
        if (is_full) begin
          res_status_next = ST_FULL;
        end else begin
          ram_en    = cmd.exec;
          ram_we    = 1'b1;
          ram_addr  = tail_inc;
          tail_next = tail_inc;
        end
      end
      REQ_POP_FRONT: begin
        if (is_empty) begin
          res_status_next = ST_EMPTY;
        end else begin
          ram_en      = cmd.exec;
          ram_addr    = head_inc;
          head_next   = head_inc;
          pop_ok_next = 1'b1;
        end
      end
      default: begin
        res_status_next = ST_DONE;
      end
    endcase
  end

  always_comb begin
    if (tail >= head) begin
      occ_diff = {1'b0, tail} - {1'b0, head};
    end else begin
      occ_diff = {1'b0, tail} + DEPTH_EXT - {1'b0, head};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= PTR_LAST;
      tail <= PTR_LAST;
    end else if (cmd.exec) begin
      head <= head_next;
      tail <= tail_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req <= in_data;
    end
    if (cmd.exec) begin
      res_status <= res_status_next;
      pop_ok     <= pop_ok_next;
    end
    if (cmd.load_out) begin
      out_data.status      <= res_status;
      out_data.popped_data <= pop_ok ? ENTRY_W'(ram_rd_data) : '0;
      out_data.occupancy   <= OCC_W'(occ_diff);
      out_data.full_flag   <= is_full;
      out_data.empty_flag  <= is_empty;
    end
  end

  cdq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .en      (ram_en),
    .we      (ram_we),
    .addr    (ram_addr),
    .wr_data (DATA_WIDTH'(req.entry_data)),
    .rd_data (ram_rd_data)
  );

endmodule

@@ rtl/core/circular_deque.sv @@
// Top level of the ring-buffer deque with front push, back push and front pop.
//
//   channel | signals                      | payload
//   --------+------------------------------+-----------------------------
//   in      | in_valid, in_ready, in_data  | req_item_t (request, word)
//   out     | out_valid, out_ready, out_data | result_item_t (status, data)
//
// Each request passes through three steps: accept, execute on the single RAM port,
// then load the output register with the registered read data.
// A new request is accepted while the previous result waits in the output
// register; a stalled output holds the request in its final cycle.
// Reset is synchronous and sets both pointers to the last slot; the entry
// store is not cleared.
module circular_deque
  import cdq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  req_item_t    in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output result_item_t out_data
);

  ctl_cmd_t cmd;

  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  cdq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

@@ tb/tb_circular_deque.sv @@
// Self-checking testbench for the circular deque: random requests checked against a predictor.
`timescale 1ns / 1ps

module tb_circular_deque;
  import cdq_pkg::*;

  localparam int PTR_W      = $clog2(DEPTH_DEF);
  localparam int FULL_OCC   = DEPTH_DEF - 1;
  localparam int N_ITEMS    = 2000;
  localparam int DRAIN_AT   = 1200;
  localparam int HOLD_AT    = 400;
  localparam int HOLD_LEN   = 160;
  localparam int IDLE_LIMIT = 2000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         in_valid = 1'b0;
  logic         in_ready;
  req_item_t    in_data = '0;
  logic         out_valid;
  logic         out_ready = 1'b0;
  result_item_t out_data;

  circular_deque u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state, kept in step with every accepted request.
  logic [PTR_W-1:0]   ring_head = PTR_W'(DEPTH_DEF - 1);
  logic [PTR_W-1:0]   ring_tail = PTR_W'(DEPTH_DEF - 1);
  logic [ENTRY_W-1:0] ring_mem [DEPTH_DEF];

  req_item_t    req_backlog [$];
  result_item_t due_results [$];

  int plan_occ      = 0;
  int plan_items    = 0;
  int total_reqs    = 0;
  int sent_cnt      = 0;
  int results_seen  = 0;
  int err_cnt       = 0;
  int n_stored      = 0;
  int n_rejected    = 0;
  int n_popped      = 0;
  int n_empty_pops  = 0;
  int n_nops        = 0;
  int send_gap      = 0;
  int recv_gap      = 0;
  int hold_left     = 0;
  int idle_cycles   = 0;
  bit send_burst    = 1'b0;
  bit recv_burst    = 1'b0;
  bit hold_done     = 1'b0;

  function automatic result_item_t predict_deque(req_item_t r);
    result_item_t res;
    res = '0;
    case (r.req_type)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (PTR_W'(ring_tail + 1'b1) == ring_head) begin
          res.status = ST_FULL;
          n_rejected++;
        end else if (r.req_type == REQ_PUSH_FRONT) begin
          ring_mem[ring_head] = r.entry_data;
          ring_head = ring_head - 1'b1;
          n_stored++;
        end else begin
          ring_tail = ring_tail + 1'b1;
          ring_mem[ring_tail] = r.entry_data;
          n_stored++;
        end
      end
      REQ_POP_FRONT: begin
        if (ring_head == ring_tail) begin
          res.status = ST_EMPTY;
          n_empty_pops++;
        end else begin
          ring_head = ring_head - 1'b1 + 2'd2;
          res.popped_data = ring_mem[ring_head];
          n_popped++;
        end
      end
      default: n_nops++;
    endcase
    res.occupancy  = OCC_W'(PTR_W'(ring_tail - ring_head));
    res.full_flag  = (PTR_W'(ring_tail + 1'b1) == ring_head);
    res.empty_flag = (ring_head == ring_tail);
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ENTRY_W-1:0] rand_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  task automatic queue_req(req_type_t t, logic [ENTRY_W-1:0] w);
    req_item_t r;
    r.req_type   = t;
    r.entry_data = w;
    req_backlog.push_back(r);
    case (t)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: if (plan_occ < FULL_OCC) plan_occ++;
      REQ_POP_FRONT: if (plan_occ > 0) plan_occ--;
      default: ;
    endcase
    if (t != REQ_NOP) plan_items++;
  endtask

  task automatic report_mismatch(string what, logic [ENTRY_W-1:0] got,
                                 logic [ENTRY_W-1:0] want);
    err_cnt++;
    if (err_cnt <= 50)
      $display("%0t: mismatch in %s: got %h, expected %h", $time, what, got, want);
  endtask

  // Request driver.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if ($urandom_range(0, 299) == 0) send_burst = !send_burst;
      if (in_valid && in_ready) begin
        due_results.push_back(predict_deque(in_data));
        sent_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (req_backlog.size() > 0 &&
                     !(sent_cnt == DRAIN_AT && due_results.size() > 0)) begin
          in_data  <= req_backlog.pop_front();
          in_valid <= 1'b1;
          send_gap = send_burst ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls.
  always @(posedge clk) begin
    result_item_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 299) == 0) recv_burst = !recv_burst;
      if (out_valid && out_ready) begin
        results_seen++;
        if (due_results.size() == 0) begin
          report_mismatch("unexpected result", out_data.popped_data, '0);
        end else begin
          want = due_results.pop_front();
          if (out_data.status !== want.status)
            report_mismatch("status", out_data.status, want.status);
          if (out_data.popped_data !== want.popped_data)
            report_mismatch("popped_data", out_data.popped_data, want.popped_data);
          if (out_data.occupancy !== want.occupancy)
            report_mismatch("occupancy", out_data.occupancy, want.occupancy);
          if (out_data.full_flag !== want.full_flag)
            report_mismatch("full_flag", out_data.full_flag, want.full_flag);
          if (out_data.empty_flag !== want.empty_flag)
            report_mismatch("empty_flag", out_data.empty_flag, want.empty_flag);
        end
        recv_gap = recv_burst ? 0 : pick_gap();
      end
      if (results_seen == HOLD_AT && !hold_done) begin
        hold_left = HOLD_LEN;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("%0t: no request or result moved for %0d cycles", $time, IDLE_LIMIT);
        $display("tb_circular_deque: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int mode;
    int extra;
    int len;
    int r;

    // Empty deque, extreme words at both ends, every request kind, back to empty.
    queue_req(REQ_POP_FRONT, 32'hFFFF_FFFF);
    queue_req(REQ_NOP, 32'h0);
    queue_req(REQ_PUSH_BACK, 32'hFFFF_FFFF);
    queue_req(REQ_PUSH_FRONT, 32'h0000_0000);
    queue_req(REQ_PUSH_FRONT, 32'h8000_0000);
    queue_req(REQ_PUSH_BACK, 32'h0000_0001);
    queue_req(REQ_NOP, 32'hFFFF_FFFF);
    queue_req(REQ_POP_FRONT, 32'h0);
    queue_req(REQ_POP_FRONT, 32'h0);
    queue_req(REQ_POP_FRONT, 32'h0);
    queue_req(REQ_POP_FRONT, 32'h0);
    queue_req(REQ_POP_FRONT, 32'h0);
    queue_req(REQ_PUSH_BACK, 32'hAAAA_AAAA);
    queue_req(REQ_PUSH_FRONT, 32'h5555_5555);
    queue_req(REQ_POP_FRONT, 32'h0);
    queue_req(REQ_POP_FRONT, 32'h0);
    queue_req(REQ_POP_FRONT, 32'h0);

    while (plan_items < N_ITEMS) begin
      mode = $urandom_range(0, 2);
      if (mode == 0) begin
        extra = $urandom_range(1, 4);
        while (extra > 0) begin
          r = $urandom_range(0, 99);
          if (r < 85) queue_req(req_type_t'($urandom_range(0, 1)), rand_word());
          else if (r < 97) queue_req(REQ_POP_FRONT, rand_word());
          else queue_req(REQ_NOP, rand_word());
          if (plan_occ == FULL_OCC) extra--;
        end
      end else if (mode == 1) begin
        extra = $urandom_range(1, 3);
        while (extra > 0) begin
          r = $urandom_range(0, 99);
          if (r < 85) queue_req(REQ_POP_FRONT, rand_word());
          else if (r < 97) queue_req(req_type_t'($urandom_range(0, 1)), rand_word());
          else queue_req(REQ_NOP, rand_word());
          if (plan_occ == 0) extra--;
        end
      end else begin
        len = $urandom_range(10, 50);
        repeat (len) begin
          r = $urandom_range(0, 99);
          if (r < 47) queue_req(req_type_t'($urandom_range(0, 1)), rand_word());
          else if (r < 95) queue_req(REQ_POP_FRONT, rand_word());
          else queue_req(REQ_NOP, rand_word());
        end
      end
    end
    total_reqs = req_backlog.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (sent_cnt < total_reqs || due_results.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (due_results.size() > 0)
      report_mismatch("missing results", due_results.size(), '0);

    $display("Ran %0d requests: %0d stored, %0d rejected on full, %0d popped,",
             total_reqs, n_stored, n_rejected, n_popped);
    $display("%0d pops on empty, %0d no-ops; %0d results checked, %0d mismatches.",
             n_empty_pops, n_nops, results_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("tb_circular_deque: PASS");
    end else begin
      $display("tb_circular_deque: FAIL");
    end
    $finish;
  end

endmodule
